// ----- rtl/core/gal_pkg.sv -----
// Shared widths and constants for the gcd and lcm unit.
package gal_pkg;

  // Operand width used by the arithmetic (range 4 to 32).
  localparam int DATA_WIDTH = 16;

  // Widths of the item fields on the ports.
  localparam int IN_W  = 16;
  localparam int GCD_W = 16;
  localparam int LCM_W = 32;

  // Operands are the low OP_W bits of a 16-bit field: DATA_WIDTH, capped at IN_W.
  localparam int OP_W   = (DATA_WIDTH < IN_W) ? DATA_WIDTH : IN_W;
  localparam int PROD_W = 2 * OP_W;
  localparam int CNT_W  = $clog2(OP_W + 1);

endpackage

// ----- rtl/core/gal_gcd.sv -----
// Binary (shift and subtract) gcd engine, one step per cycle.
module gal_gcd (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [gal_pkg::OP_W-1:0] a_in,
  input  logic [gal_pkg::OP_W-1:0] b_in,
  output logic                  done,
  output logic [gal_pkg::OP_W-1:0] gcd
);
  import gal_pkg::*;

  logic            busy;
  logic [OP_W-1:0] a;
  logic [OP_W-1:0] b;
  logic [CNT_W-1:0] k;
  logic [OP_W-1:0] a_next;
  logic [OP_W-1:0] b_next;
  logic [CNT_W-1:0] k_next;
  logic            finish;

  // Finish once either working value has dropped to zero.
  assign finish = (a == '0) || (b == '0);

  // Pick one step: common factor of two, single halving, or subtract.
  always_comb begin
    a_next = a;
    b_next = b;
    k_next = k;
    if (!a[0] && !b[0]) begin
      a_next = a >> 1;
      b_next = b >> 1;
      k_next = k + CNT_W'(1);
    end else if (!a[0]) begin
      a_next = a >> 1;
    end else if (!b[0]) begin
      b_next = b >> 1;
    end else if (a >= b) begin
      a_next = a - b;
    end else begin
      b_next = b - a;
    end
  end

  // Hold the working values and advance one step a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && finish;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && finish) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      a <= a_in;
      b <= b_in;
      k <= '0;
    end else if (busy && !finish) begin
      a <= a_next;
      b <= b_next;
      k <= k_next;
    end else if (busy && finish) begin
      gcd <= OP_W'((a | b) << k);
    end
  end

endmodule

// ----- rtl/core/gal_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gal_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [gal_pkg::OP_W-1:0] dividend,
  input  logic [gal_pkg::OP_W-1:0] divisor,
  output logic                  done,
  output logic [gal_pkg::OP_W-1:0] quotient
);
  import gal_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [OP_W:0]    rem;
  logic [OP_W-1:0]  dvs;
  logic [OP_W:0]    rem_sh;
  logic [OP_W:0]    diff;
  logic             fits;

  // Bring down the next dividend bit and try the subtraction.
  assign rem_sh = {rem[OP_W-1:0], quotient[OP_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(OP_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff : rem_sh;
      quotient <= {quotient[OP_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/gcd_and_lcm_unit_core.sv -----
// Top level of the gcd and lcm unit: sequencer, product step and output register.
//
// Usage: an item on the input channel (in_valid/in_ready) carries two
// unsigned 16-bit operands, first_value and second_value. Each item gives
// exactly one item on the output channel (out_valid/out_ready): gcd_value,
// lcm_value and zero_operand. When either operand is zero, zero_operand is
// 1 and both results are 0.
// One item is worked on at a time; in_ready is high only while idle.
// Steps: a zero operand goes straight to the hold state and the output
// register. Otherwise the binary gcd engine runs its shift and subtract
// steps, data dependent in number; the restoring divider then divides
// the smaller operand by the gcd, the quotient is multiplied by the larger
// operand in S_MUL, and the result is loaded into the output register.
// The output register lets the core take a new item while a result waits;
// if the receiver stalls, the next result waits in the sequencer and
// in_ready stays low until the output register frees up.
// Reset (rst, synchronous) clears the sequencer and drops out_valid.
module gcd_and_lcm_unit_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [gal_pkg::IN_W-1:0] first_value,
  input  logic [gal_pkg::IN_W-1:0] second_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [gal_pkg::GCD_W-1:0] gcd_value,
  output logic [gal_pkg::LCM_W-1:0] lcm_value,
  output logic                     zero_operand
);
  import gal_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV,
    S_MUL,
    S_HOLD
  } state_t;

  state_t          state;
  logic [OP_W-1:0] a_op;
  logic [OP_W-1:0] b_op;
  logic [OP_W-1:0] lo_op;
  logic [OP_W-1:0] hi_op;
  logic [OP_W-1:0] lo;
  logic [OP_W-1:0] hi;
  logic            accept;
  logic            has_zero;
  logic            gcd_start;
  logic            gcd_done;
  logic [OP_W-1:0] gcd_res;
  logic            div_done;
  logic [OP_W-1:0] quo;
  logic [GCD_W-1:0] res_gcd;
  logic [LCM_W-1:0] res_lcm;
  logic            res_zero;
  logic [PROD_W-1:0] prod;
  logic            out_free;
  logic            out_load;

  // Mask operands to the working width and order them.
  assign a_op     = first_value[OP_W-1:0];
  assign b_op     = second_value[OP_W-1:0];
  assign lo_op    = (a_op > b_op) ? b_op : a_op;
  assign hi_op    = (a_op > b_op) ? a_op : b_op;
  assign has_zero = (a_op == '0) || (b_op == '0);

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign gcd_start = accept && !has_zero;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == S_HOLD) && out_free;
  assign prod      = quo * hi;

  gal_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a_in  (hi_op),
    .b_in  (lo_op),
    .done  (gcd_done),
    .gcd   (gcd_res)
  );

  gal_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (gcd_done),
    .dividend (lo),
    .divisor  (gcd_res),
    .done     (div_done),
    .quotient (quo)
  );

  // Sequence the item through gcd, divide and multiply, then hand it off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on a load, drop it once the item is taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lo <= lo_op;
            hi <= hi_op;
            if (has_zero) begin
              res_gcd  <= '0;
              res_lcm  <= '0;
              res_zero <= 1'b1;
              state    <= S_HOLD;
            end else begin
              res_zero <= 1'b0;
              state    <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            res_gcd <= GCD_W'(gcd_res);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          res_lcm <= LCM_W'(prod);
          state   <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            gcd_value    <= res_gcd;
            lcm_value    <= res_lcm;
            zero_operand <= res_zero;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
